@@ design/assert_macros.svh @@
// Assertion macros used by the checker file ssfl_checker.sv.
// Each macro samples on clk and stays quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that prop holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Assert that cond never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ design/ssfl_pkg.sv @@
// Package for the SPI slave frame link: commands, link phases, result beat type.
// No dependencies; used by spi_slave_frame_link.
package ssfl_pkg;

    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] FILLER_BYTE = 8'h99;

    typedef enum logic [1:0] {
        CMD_RX   = 2'd0,
        CMD_SLOT = 2'd1,
        CMD_PUSH = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_SIZE = 3'b010,
        PH_XFER = 3'b100
    } phase_t;

    localparam logic [1:0] LINK_WAIT = 2'd0;
    localparam logic [1:0] LINK_SIZE = 2'd1;
    localparam logic [1:0] LINK_XFER = 2'd2;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_APP     = 2'd1;
    localparam logic [1:0] KIND_CMD     = 2'd2;
    localparam logic [1:0] KIND_PAYLOAD = 2'd3;

    typedef struct packed {
        logic              drive_valid;
        logic [BYTE_W-1:0] drive_byte;
        logic [1:0]        rx_kind;
        logic [BYTE_W-1:0] rx_byte;
        logic [BYTE_W-1:0] payload_index;
        logic              frame_done;
        logic [1:0]        link_phase;
        logic [BYTE_W-1:0] queued_count;
        logic              dropped_oldest;
    } result_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        unique case (ph)
            PH_WAIT: code = LINK_WAIT;
            PH_SIZE: code = LINK_SIZE;
            PH_XFER: code = LINK_XFER;
            default: code = LINK_WAIT;
        endcase
        return code;
    endfunction

endpackage

@@ design/spi_slave_frame_link.sv @@
// SPI slave frame link: link phase control, output byte ring, frame byte labelling.
// Depends on ssfl_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   item    | item_valid/item_stall| command, data_byte
//   result  | result_valid/        | drive_valid, drive_byte, rx_kind, rx_byte,
//           |   result_stall       | payload_index, frame_done, link_phase,
//           |                      | queued_count, dropped_oldest
//
// One item per cycle while item_stall is low; each result reaches the ports through the
// ring read register, loaded at the accepting edge, and then the output register.
// The ring is a RING_DEPTH x 8 memory with one write and one registered read port.
// Reset clears phase, ring pointers and counters; ring contents stay undefined.
// item_stall rises only while both result stages are full and result_stall is high.
module spi_slave_frame_link #(
    parameter int RING_DEPTH = 128
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic [1:0]                command,
    input  logic [ssfl_pkg::BYTE_W-1:0] data_byte,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic                      drive_valid,
    output logic [ssfl_pkg::BYTE_W-1:0] drive_byte,
    output logic [1:0]                rx_kind,
    output logic [ssfl_pkg::BYTE_W-1:0] rx_byte,
    output logic [ssfl_pkg::BYTE_W-1:0] payload_index,
    output logic                      frame_done,
    output logic [1:0]                link_phase,
    output logic [ssfl_pkg::BYTE_W-1:0] queued_count,
    output logic                      dropped_oldest
);
    import ssfl_pkg::*;

    localparam int IW = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
    localparam logic [IW-1:0]     LAST_IDX  = IW'(RING_DEPTH - 1);
    localparam logic [BYTE_W-1:0] DEPTH_CNT = BYTE_W'(RING_DEPTH);

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    phase_t            phase_reg,  phase_next;
    logic [IW-1:0]     head_reg,   head_next;
    logic [IW-1:0]     tail_reg,   tail_next;
    logic [BYTE_W-1:0] count_reg,  count_next;
    logic [BYTE_W-1:0] rem_reg,    rem_next;
    logic [BYTE_W-1:0] total_reg,  total_next;
    logic [BYTE_W-1:0] recv_reg,   recv_next;

    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    logic    b_valid_reg, o_valid_reg;
    logic    b_use_ring_reg;
    result_t b_res_reg, o_res_reg;
    result_t b_out;
    result_t res_next;
    logic    use_ring;
    logic    do_pop, do_push;
    logic    accept, b_adv;
    logic [BYTE_W-1:0] recv_inc, rem_dec;

    assign b_adv      = b_valid_reg && (!o_valid_reg || !result_stall);
    assign item_stall = b_valid_reg && o_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    assign recv_inc = recv_reg + 8'd1;
    assign rem_dec  = rem_reg - 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        total_next = total_reg;
        recv_next  = recv_reg;
        res_next   = '0;
        use_ring   = 1'b0;
        do_pop     = 1'b0;
        do_push    = 1'b0;

        unique case (cmd_t'(command))
            CMD_RX:
            begin
                if (phase_reg == PH_WAIT && data_byte == FILLER_BYTE)
                begin
                    rem_next             = count_reg;
                    phase_next           = PH_SIZE;
                    res_next.drive_valid = 1'b1;
                    res_next.drive_byte  = count_reg;
                end
                else if (phase_reg == PH_SIZE)
                begin
                    total_next = data_byte;
                    recv_next  = '0;
                    phase_next = (data_byte != '0 || rem_reg != '0) ? PH_XFER : PH_WAIT;
                end
                else if (phase_reg == PH_XFER && recv_reg < total_reg)
                begin
                    if (recv_reg == 8'd0)
                        res_next.rx_kind = KIND_APP;
                    else if (recv_reg == 8'd1)
                        res_next.rx_kind = KIND_CMD;
                    else
                    begin
                        res_next.rx_kind       = KIND_PAYLOAD;
                        res_next.payload_index = recv_reg - 8'd2;
                    end
                    res_next.rx_byte = data_byte;
                    recv_next        = recv_inc;
                    if (recv_inc == total_reg)
                    begin
                        total_next          = '0;
                        res_next.frame_done = 1'b1;
                        if (rem_reg == '0)
                            phase_next = PH_WAIT;
                    end
                end
            end
            CMD_SLOT:
            begin
                res_next.drive_valid = 1'b1;
                res_next.drive_byte  = FILLER_BYTE;
                if (phase_reg != PH_WAIT && rem_reg != '0 && count_reg != '0)
                begin
                    rem_next = rem_dec;
                    if (rem_dec == '0 && total_reg == '0)
                        phase_next = PH_WAIT;
                    use_ring   = 1'b1;
                    do_pop     = 1'b1;
                    count_next = count_reg - 8'd1;
                    tail_next  = ring_next(tail_reg);
                end
            end
            CMD_PUSH:
            begin
                do_push   = 1'b1;
                head_next = ring_next(head_reg);
                if (count_reg >= DEPTH_CNT)
                begin
                    tail_next               = ring_next(tail_reg);
                    res_next.dropped_oldest = 1'b1;
                end
                else
                    count_next = count_reg + 8'd1;
            end
            CMD_NOP:
            begin
            end
            default:
            begin
            end
        endcase

        res_next.link_phase   = phase_code(phase_next);
        res_next.queued_count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            rem_reg     <= '0;
            total_reg   <= '0;
            recv_reg    <= '0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                rem_reg   <= rem_next;
                total_reg <= total_next;
                recv_reg  <= recv_next;
            end
            if (accept)
                b_valid_reg <= 1'b1;
            else if (b_adv)
                b_valid_reg <= 1'b0;
            if (b_adv)
                o_valid_reg <= 1'b1;
            else if (!result_stall)
                o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && do_push)
            ring_mem[head_reg] <= data_byte;
        if (accept && do_pop)
            rd_data_reg <= ring_mem[tail_reg];
    end

    always_comb
    begin
        b_out = b_res_reg;
        if (b_use_ring_reg)
            b_out.drive_byte = rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_res_reg      <= res_next;
            b_use_ring_reg <= use_ring;
        end
        if (b_adv)
            o_res_reg <= b_out;
    end

    assign result_valid   = o_valid_reg;
    assign drive_valid    = o_res_reg.drive_valid;
    assign drive_byte     = o_res_reg.drive_byte;
    assign rx_kind        = o_res_reg.rx_kind;
    assign rx_byte        = o_res_reg.rx_byte;
    assign payload_index  = o_res_reg.payload_index;
    assign frame_done     = o_res_reg.frame_done;
    assign link_phase     = o_res_reg.link_phase;
    assign queued_count   = o_res_reg.queued_count;
    assign dropped_oldest = o_res_reg.dropped_oldest;

endmodule

@@ design/ssfl_checker.sv @@
// Port-level checker for spi_slave_frame_link, with its bind statement.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ssfl_checker #(
    parameter int RING_DEPTH = 128
) (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_stall,
    input logic [1:0] command,
    input logic [7:0] data_byte,
    input logic       result_valid,
    input logic       result_stall,
    input logic       drive_valid,
    input logic [7:0] drive_byte,
    input logic [1:0] rx_kind,
    input logic [7:0] rx_byte,
    input logic [7:0] payload_index,
    input logic       frame_done,
    input logic [1:0] link_phase,
    input logic [7:0] queued_count,
    input logic       dropped_oldest
);

    `ASSERT_CLK(a_hold_beat, result_valid && result_stall |=> result_valid && $stable(drive_byte) && $stable(queued_count), "stalled result beat changed")
    `ASSERT_NEVER(a_count_bound, result_valid && queued_count > 8'(RING_DEPTH), "queued count exceeds ring depth")
    `ASSERT_CLK(a_drop_full, result_valid && dropped_oldest |-> queued_count == 8'(RING_DEPTH) && !drive_valid, "drop reported without full ring")
    `ASSERT_CLK(a_done_kind, result_valid && frame_done |-> rx_kind != 2'd0, "frame done without a frame byte")
    `ASSERT_CLK(a_idle_rx, result_valid && rx_kind == 2'd0 |-> rx_byte == 8'd0 && payload_index == 8'd0 && !frame_done, "receive fields set without a frame byte")

endmodule

bind spi_slave_frame_link ssfl_checker #(.RING_DEPTH(RING_DEPTH)) u_ssfl_checker (.*);
